/* design/dvkf_pkg.sv */
package dvkf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W = 32;
    localparam int CFG_W = 24;
    localparam int DT_W = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_Q_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Q_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R_MEAS = 2'd2;

    localparam logic [CFG_W-1:0] Q_DEPTH_RESET = 24'd328;
    localparam logic [CFG_W-1:0] Q_RATE_RESET = 24'd131;
    localparam logic [CFG_W-1:0] R_MEAS_RESET = 24'd6554;

    localparam logic signed [DATA_W-1:0] P00_RESET = 32'sd131072;
    localparam logic signed [DATA_W-1:0] P11_RESET = 32'sd65536;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

    function automatic logic signed [DATA_W-1:0] sat34(input logic signed [33:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 34'sh07fffffff) r = S32_MAX;
        else if (v < -34'sh080000000) r = S32_MIN;
        else r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

/* design/depth_velocity_kalman_filter_top.sv */
// Two-state depth and depth-rate Kalman filter in signed Q16.16. One transfer
// on the input channel gives exactly one transfer on the output channel. All
// arithmetic goes through one shared 32x32 multiplier and one saturating adder
// under a step sequencer, and the two gains come from a bit-serial divider
// that produces one quotient bit per cycle. When the innovation variance is
// positive, the result is offered after 13 prediction steps, two divisions and
// 10 update steps. When the variance is not positive, the divisions and
// updates are skipped, and the result is offered after the prediction steps.
// The block accepts no new item until the result has been transferred, so a
// new item can be taken in the cycle after that. Configuration writes take
// effect immediately and are expected only while the block is idle.
module depth_velocity_kalman_filter_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [31:0]        raw_depth,
    input  logic signed [31:0]        depth_correction,
    input  logic [16:0]               time_step,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [31:0]        depth_estimate,
    output logic signed [31:0]        rate_estimate,
    input  logic                      cfg_write,
    input  logic [1:0]                cfg_index,
    input  logic [23:0]               cfg_data
);

    localparam int DW = dvkf_pkg::DATA_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CALC = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;

    // Micro-op codes for the step sequencer.
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;

    // Register file slots.
    localparam logic [3:0] R_XD  = 4'd0;
    localparam logic [3:0] R_XR  = 4'd1;
    localparam logic [3:0] R_P00 = 4'd2;
    localparam logic [3:0] R_P01 = 4'd3;
    localparam logic [3:0] R_P11 = 4'd4;
    localparam logic [3:0] R_DT  = 4'd5;
    localparam logic [3:0] R_Z   = 4'd6;
    localparam logic [3:0] R_T   = 4'd7;
    localparam logic [3:0] R_Y   = 4'd8;
    localparam logic [3:0] R_S   = 4'd9;
    localparam logic [3:0] R_K0  = 4'd10;
    localparam logic [3:0] R_K1  = 4'd11;
    localparam logic [3:0] R_QD  = 4'd12;
    localparam logic [3:0] R_QR  = 4'd13;
    localparam logic [3:0] R_RM  = 4'd14;
    localparam logic [3:0] R_CR  = 4'd15;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] d;
    } uop_t;

    localparam int NPRE = 14;
    localparam int NPOST = 10;

    function automatic uop_t pre_op(input logic [3:0] i);
        uop_t u;
        unique case (i)
            4'd0:  u = '{OP_MUL, R_DT, R_XR, R_T};
            4'd1:  u = '{OP_ADD, R_XD, R_T, R_XD};
            4'd2:  u = '{OP_MUL, R_DT, R_P01, R_T};
            4'd3:  u = '{OP_ADD, R_P00, R_T, R_P00};
            4'd4:  u = '{OP_MUL, R_DT, R_P11, R_T};
            4'd5:  u = '{OP_ADD, R_P01, R_T, R_P01};
            4'd6:  u = '{OP_MUL, R_DT, R_P01, R_T};
            4'd7:  u = '{OP_ADD, R_P00, R_T, R_P00};
            4'd8:  u = '{OP_ADD, R_P00, R_QD, R_P00};
            4'd9:  u = '{OP_ADD, R_P11, R_QR, R_P11};
            4'd10: u = '{OP_ADD, R_Z, R_CR, R_Z};
            4'd11: u = '{OP_SUB, R_Z, R_XD, R_Y};
            4'd12: u = '{OP_ADD, R_P00, R_RM, R_S};
            default: u = '{OP_ADD, R_P00, R_RM, R_S};
        endcase
        return u;
    endfunction

    function automatic uop_t post_op(input logic [3:0] i);
        uop_t u;
        unique case (i)
            4'd0: u = '{OP_MUL, R_K0, R_Y, R_T};
            4'd1: u = '{OP_ADD, R_XD, R_T, R_XD};
            4'd2: u = '{OP_MUL, R_K1, R_Y, R_T};
            4'd3: u = '{OP_ADD, R_XR, R_T, R_XR};
            4'd4: u = '{OP_MUL, R_K1, R_P01, R_T};
            4'd5: u = '{OP_SUB, R_P11, R_T, R_P11};
            4'd6: u = '{OP_MUL, R_K0, R_P00, R_T};
            4'd7: u = '{OP_SUB, R_P00, R_T, R_P00};
            4'd8: u = '{OP_MUL, R_K0, R_P01, R_T};
            default: u = '{OP_SUB, R_P01, R_T, R_P01};
        endcase
        return u;
    endfunction

    logic [2:0] state_reg, state_next;
    logic       post_reg, post_next;
    logic [3:0] step_reg, step_next;
    logic signed [DW-1:0] rf_reg [16];
    logic [DW-1:0] cfg_q_depth_reg, cfg_q_rate_reg, cfg_r_meas_reg;

    logic       div_sel_reg;
    logic [5:0] div_cnt_reg;
    logic [48:0] div_num_reg;
    logic [48:0] div_quo_reg;
    logic [32:0] div_rem_reg;
    logic        div_neg_reg;

    uop_t uop;
    logic signed [DW-1:0] opa, opb, res;
    logic signed [63:0] prod;
    logic signed [63:0] prod_r;
    logic signed [47:0] prod_sh;
    logic signed [33:0] sum;

    logic [33:0] rem_try;
    logic        div_bit;
    logic [48:0] quo_mag;
    logic signed [49:0] quo_s;
    logic signed [DW-1:0] quo_sat;
    logic signed [DW-1:0] num_v;
    logic [DW-1:0] num_abs;

    always_comb
    begin
        uop = post_reg ? post_op(step_reg) : pre_op(step_reg);
        opa = rf_reg[uop.a];
        opb = rf_reg[uop.b];
        prod = opa * opb;
        prod_r = prod + 64'sd32768;
        prod_sh = prod_r[63:16];
        if (prod_sh > 48'sh00007fffffff) res = dvkf_pkg::S32_MAX;
        else if (prod_sh < -48'sh000080000000) res = dvkf_pkg::S32_MIN;
        else res = prod_sh[31:0];
        sum = '0;
        case (uop.op)
            OP_ADD:  sum = 34'(opa) + 34'(opb);
            OP_SUB:  sum = 34'(opa) - 34'(opb);
            default: sum = '0;
        endcase
        if (uop.op != OP_MUL) res = dvkf_pkg::sat34(sum);
    end

    always_comb
    begin
        num_v = div_sel_reg ? rf_reg[R_P01] : rf_reg[R_P00];
        num_abs = num_v[DW-1] ? 32'(-num_v) : 32'(num_v);
        rem_try = {div_rem_reg, div_num_reg[48]} - {2'b00, rf_reg[R_S]};
        div_bit = !rem_try[33];
        quo_mag = {div_quo_reg[47:0], div_bit};
        quo_s = div_neg_reg ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});
        if (quo_s > 50'sh0007fffffff) quo_sat = dvkf_pkg::S32_MAX;
        else if (quo_s < -50'sh00080000000) quo_sat = dvkf_pkg::S32_MIN;
        else quo_sat = quo_s[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        post_next = post_reg;
        step_next = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CALC;
                    post_next = 1'b0;
                    step_next = '0;
                end
            end
            ST_CALC:
            begin
                step_next = step_reg + 4'd1;
                if (!post_reg && step_reg == 4'(NPRE - 2))
                begin
                    state_next = (res > 0) ? ST_DIV : ST_OUT;
                end
                else if (post_reg && step_reg == 4'(NPOST - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == 6'd48 && div_sel_reg)
                begin
                    state_next = ST_CALC;
                    post_next = 1'b1;
                    step_next = '0;
                end
            end
            ST_OUT:
            begin
                if (!out_stall) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            post_reg <= 1'b0;
            step_reg <= '0;
            rf_reg[R_XD] <= '0;
            rf_reg[R_XR] <= '0;
            rf_reg[R_P00] <= dvkf_pkg::P00_RESET;
            rf_reg[R_P01] <= '0;
            rf_reg[R_P11] <= dvkf_pkg::P11_RESET;
            cfg_q_depth_reg <= 32'(dvkf_pkg::Q_DEPTH_RESET);
            cfg_q_rate_reg <= 32'(dvkf_pkg::Q_RATE_RESET);
            cfg_r_meas_reg <= 32'(dvkf_pkg::R_MEAS_RESET);
            div_sel_reg <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            post_reg <= post_next;
            step_reg <= step_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    dvkf_pkg::REG_Q_DEPTH: cfg_q_depth_reg <= 32'(cfg_data);
                    dvkf_pkg::REG_Q_RATE:  cfg_q_rate_reg <= 32'(cfg_data);
                    dvkf_pkg::REG_R_MEAS:  cfg_r_meas_reg <= 32'(cfg_data);
                    default: ;
                endcase
            end
            if (state_reg == ST_IDLE && in_valid)
            begin
                rf_reg[R_DT] <= 32'(time_step);
                rf_reg[R_Z] <= raw_depth;
                rf_reg[R_CR] <= depth_correction;
                rf_reg[R_QD] <= cfg_q_depth_reg;
                rf_reg[R_QR] <= cfg_q_rate_reg;
                rf_reg[R_RM] <= cfg_r_meas_reg;
                div_sel_reg <= 1'b0;
                div_cnt_reg <= '0;
            end
            if (state_reg == ST_CALC)
            begin
                rf_reg[uop.d] <= res;
                if (!post_reg && step_reg == 4'(NPRE - 2))
                begin
                    div_num_reg <= {num_abs, 17'd0} >> 1;
                    div_neg_reg <= rf_reg[R_P00][DW-1];
                    div_rem_reg <= '0;
                    div_quo_reg <= '0;
                    div_cnt_reg <= '0;
                    div_sel_reg <= 1'b0;
                end
            end
            if (state_reg == ST_DIV)
            begin
                if (div_cnt_reg == 6'd48)
                begin
                    rf_reg[div_sel_reg ? R_K1 : R_K0] <= quo_sat;
                    div_sel_reg <= 1'b1;
                    div_cnt_reg <= '0;
                    div_rem_reg <= '0;
                    div_quo_reg <= '0;
                    div_num_reg <= {1'b0, rf_reg[R_P01][DW-1] ? 32'(-rf_reg[R_P01])
                                                              : 32'(rf_reg[R_P01]), 16'd0};
                    div_neg_reg <= rf_reg[R_P01][DW-1];
                end
                else
                begin
                    div_rem_reg <= div_bit ? rem_try[32:0]
                                           : {div_rem_reg[31:0], div_num_reg[48]};
                    div_num_reg <= {div_num_reg[47:0], 1'b0};
                    div_quo_reg <= quo_mag;
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                end
            end
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign depth_estimate = rf_reg[R_XD];
    assign rate_estimate = rf_reg[R_XR];

    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("result shown while block ready");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(depth_estimate))
        else $error("result lost under stall");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block not busy after accepting an item");

endmodule
